// File: rtl/pwmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwmc_pkg
// Shared constants and types for the PWM period and duty calculator.
// ----------------------------------------------------------------------------
package pwmc_pkg;

	localparam int DIV_W = 32;

	localparam logic [25:0] FREQ_MAX     = 26'd40000000;
	localparam logic [13:0] DUTY_FULL    = 14'd10000;
	localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
	localparam logic [13:0] SQW_DUTY     = 14'd5000;
	localparam logic [27:0] CLK_RESET    = 28'd48000000;

	// ceil(2^45 / 10000) split in halves; (x * recip) >> 45 == x / 10000 for 32-bit x
	localparam logic [15:0] RECIP_LO     = 16'h1759;
	localparam logic [15:0] RECIP_HI     = 16'hD1B7;

	localparam logic [3:0] MODE_STOP    = 4'd0;
	localparam logic [3:0] MODE_SQW     = 4'd6;
	localparam logic [3:0] MODE_PWM     = 4'd7;
	localparam logic [3:0] ONLY_CHANNEL = 4'd11;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_CHAN = 2'd1;
	localparam logic [1:0] ST_MODE = 2'd2;

	localparam logic [3:0] LEN_OK  = 4'd15;
	localparam logic [3:0] LEN_ERR = 4'd8;

	// side data riding along the quotient divider
	typedef struct packed {
		logic [3:0]  func;
		logic [3:0]  chan;
		logic [7:0]  tag;
		logic [13:0] duty;
		logic [27:0] dclk;
		logic [1:0]  k;
	} sb_a_t;

	// side data riding along the pulse computation
	typedef struct packed {
		logic [3:0]  func;
		logic [3:0]  chan;
		logic [7:0]  tag;
		logic [27:0] dclk;
		logic [1:0]  k;
		logic [15:0] period;
	} sb_b_t;

	// side data riding along the frequency and duty dividers
	typedef struct packed {
		logic [3:0]  func;
		logic [3:0]  chan;
		logic [7:0]  tag;
		logic [1:0]  k;
		logic [15:0] period;
		logic [15:0] pulse;
	} sb_c_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  reply_length;
		logic [26:0] actual_freq;
		logic [13:0] actual_duty;
		logic [15:0] period_count;
		logic [15:0] pulse_count;
		logic [1:0]  clock_select;
		logic [7:0]  tag_echo;
		logic        start_pair;
		logic        stop_channel;
	} rsp_t;

endpackage
`default_nettype wire

// File: rtl/pwmc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwmc_cmd_if / pwmc_rsp_if
// Valid/ready channels for commands and replies.
// ----------------------------------------------------------------------------
interface pwmc_cmd_if;
	logic        valid;
	logic        ready;
	logic [3:0]  func;
	logic [3:0]  channel;
	logic [31:0] requested_freq;
	logic [15:0] requested_duty;
	logic [7:0]  tag;

	modport source (output valid, func, channel, requested_freq, requested_duty, tag,
		input ready);
	modport sink (input valid, func, channel, requested_freq, requested_duty, tag,
		output ready);
endinterface

interface pwmc_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  reply_length;
	logic [26:0] actual_freq;
	logic [13:0] actual_duty;
	logic [15:0] period_count;
	logic [15:0] pulse_count;
	logic [1:0]  clock_select;
	logic [7:0]  tag_echo;
	logic        start_pair;
	logic        stop_channel;

	modport source (output valid, status, reply_length, actual_freq, actual_duty,
		period_count, pulse_count, clock_select, tag_echo, start_pair, stop_channel,
		input ready);
	modport sink (input valid, status, reply_length, actual_freq, actual_duty,
		period_count, pulse_count, clock_select, tag_echo, start_pair, stop_channel,
		output ready);
endinterface
`default_nettype wire

// File: rtl/pwm_period_duty_calculator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_period_duty_calculator
// Prescaler choice, period/pulse counts and achieved frequency and duty.
// ----------------------------------------------------------------------------
// Pipeline: the input register loads on accept, then two 32-stage dividers, four
// mid stages and the output register lie between the command and reply valid.
// Throughput: one command per cycle; when the sink stalls a reply waits in a
// skid slot and the pipeline holds while the slot is full.
// Reset: pipeline valids and output slots clear; clock register = 48 MHz.
module pwm_period_duty_calculator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [27:0] cfg_wdata,
	pwmc_cmd_if.sink         cmd,
	pwmc_rsp_if.source       rsp
);

	logic [27:0] clk_hz_q;
	logic        adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= pwmc_pkg::CLK_RESET;
		end else if (cfg_we) begin
			clk_hz_q <= cfg_wdata;
		end
	end

	// ---------------- stage 1: clamp, prescaler ----------------
	logic [25:0] freqc;
	logic [13:0] dutyc;
	logic [1:0]  k;

	always_comb begin
		if (cmd.requested_freq > 32'(pwmc_pkg::FREQ_MAX)) begin
			freqc = pwmc_pkg::FREQ_MAX;
		end else if (cmd.requested_freq == '0) begin
			freqc = 26'd1;
		end else begin
			freqc = cmd.requested_freq[25:0];
		end
		dutyc = (cmd.requested_duty > 16'(pwmc_pkg::DUTY_FULL)) ? pwmc_pkg::DUTY_FULL
			: cmd.requested_duty[13:0];
		if (freqc > 26'(clk_hz_q >> 16)) begin
			k = 2'd0;
		end else if (freqc > 26'(clk_hz_q >> 20)) begin
			k = 2'd1;
		end else if (freqc > 26'(clk_hz_q >> 24)) begin
			k = 2'd2;
		end else begin
			k = 2'd3;
		end
	end

	logic            v_s1;
	logic [25:0]     freq_s1;
	pwmc_pkg::sb_a_t sba_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			freq_s1     <= freqc;
			sba_s1.func <= cmd.func;
			sba_s1.chan <= cmd.channel;
			sba_s1.tag  <= cmd.tag;
			sba_s1.duty <= dutyc;
			sba_s1.k    <= k;
			sba_s1.dclk <= clk_hz_q >> {k, 2'b00};
		end
	end

	// ---------------- divider A: q = dclk / freq ----------------
	logic        va;
	logic [31:0] qa;
	pwmc_pkg::sb_a_t sba_d [pwmc_pkg::DIV_W];

	pwmc_div u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s1),
		.num      ({4'd0, sba_s1.dclk}),
		.den      ({6'd0, freq_s1}),
		.out_valid(va),
		.quo      (qa)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sba_d[0] <= sba_s1;
			for (int i = 1; i < pwmc_pkg::DIV_W; i++) sba_d[i] <= sba_d[i-1];
		end
	end

	// ---------------- stage 2: period, q * duty ----------------
	pwmc_pkg::sb_a_t sba;
	logic [31:0] qm1;
	logic [31:0] qh;
	logic [15:0] period2;

	assign sba = sba_d[pwmc_pkg::DIV_W-1];

	always_comb begin
		qm1 = qa - 32'd1;
		qh  = (qa >> 1) - 32'd1;
		if (sba.func == pwmc_pkg::MODE_PWM) begin
			period2 = (qm1 > 32'(pwmc_pkg::COUNT_MAX)) ? pwmc_pkg::COUNT_MAX : qm1[15:0];
			if (period2 == '0) period2 = 16'd1;
		end else if (sba.func == pwmc_pkg::MODE_SQW) begin
			period2 = (qh > 32'(pwmc_pkg::COUNT_MAX)) ? pwmc_pkg::COUNT_MAX : qh[15:0];
		end else begin
			period2 = '0;
		end
	end

	logic            v_s2;
	logic [31:0]     prod_s2;
	pwmc_pkg::sb_b_t sbb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= va;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2       <= 32'(qa * {18'd0, sba.duty});
			sbb_s2.func   <= sba.func;
			sbb_s2.chan   <= sba.chan;
			sbb_s2.tag    <= sba.tag;
			sbb_s2.dclk   <= sba.dclk;
			sbb_s2.k      <= sba.k;
			sbb_s2.period <= period2;
		end
	end

	// ---------------- stages 2a/2b: pulse = q * duty / 10000 ----------------
	// reciprocal multiply as two 32x16 partial products, then sum and shift
	logic            v_s2a;
	logic [47:0]     plo_s2a;
	logic [47:0]     phi_s2a;
	pwmc_pkg::sb_b_t sbb_s2a;
	logic [63:0]     psum;
	logic            v_s2b;
	logic [31:0]     qb_s2b;
	pwmc_pkg::sb_b_t sbb_s2b;
	logic            vb;
	logic [31:0]     qb;

	assign psum = {16'd0, plo_s2a} + {phi_s2a, 16'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2a <= 1'b0;
			v_s2b <= 1'b0;
		end else if (adv) begin
			v_s2a <= v_s2;
			v_s2b <= v_s2a;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			plo_s2a <= {16'd0, prod_s2} * {32'd0, pwmc_pkg::RECIP_LO};
			phi_s2a <= {16'd0, prod_s2} * {32'd0, pwmc_pkg::RECIP_HI};
			sbb_s2a <= sbb_s2;
			qb_s2b  <= {13'd0, psum[63:45]};
			sbb_s2b <= sbb_s2a;
		end
	end

	assign vb = v_s2b;
	assign qb = qb_s2b;

	// ---------------- stage 3: pulse clamp, divisors ----------------
	pwmc_pkg::sb_b_t sbb;
	logic [15:0] pulse3;
	logic [16:0] p1;

	assign sbb = sbb_s2b;
	assign p1  = {1'b0, sbb.period} + 17'd1;

	always_comb begin
		if (sbb.func != pwmc_pkg::MODE_PWM) begin
			pulse3 = '0;
		end else if (qb >= {16'd0, sbb.period}) begin
			pulse3 = sbb.period - 16'd1;
		end else begin
			pulse3 = qb[15:0];
		end
	end

	logic            v_s3;
	logic [31:0]     fden_s3;
	logic [31:0]     dnum_s3;
	logic [31:0]     dden_s3;
	logic [27:0]     dclk_s3;
	pwmc_pkg::sb_c_t sbc_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= vb;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fden_s3 <= (sbb.func == pwmc_pkg::MODE_SQW) ? {14'd0, p1, 1'b0} : {15'd0, p1};
			dnum_s3 <= {2'd0, 30'(pulse3 * pwmc_pkg::DUTY_FULL)};
			dden_s3 <= {15'd0, p1};
			dclk_s3 <= sbb.dclk;
			sbc_s3.func   <= sbb.func;
			sbc_s3.chan   <= sbb.chan;
			sbc_s3.tag    <= sbb.tag;
			sbc_s3.k      <= sbb.k;
			sbc_s3.period <= sbb.period;
			sbc_s3.pulse  <= pulse3;
		end
	end

	// ---------------- dividers C and D: achieved frequency and duty ----------------
	logic        vc;
	logic        vd;
	logic [31:0] qc;
	logic [31:0] qd;
	pwmc_pkg::sb_c_t sbc_d [pwmc_pkg::DIV_W];

	pwmc_div u_div_c (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s3),
		.num      ({4'd0, dclk_s3}),
		.den      (fden_s3),
		.out_valid(vc),
		.quo      (qc)
	);

	pwmc_div u_div_d (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s3),
		.num      (dnum_s3),
		.den      (dden_s3),
		.out_valid(vd),
		.quo      (qd)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sbc_d[0] <= sbc_s3;
			for (int i = 1; i < pwmc_pkg::DIV_W; i++) sbc_d[i] <= sbc_d[i-1];
		end
	end

	// ---------------- reply assembly ----------------
	pwmc_pkg::sb_c_t sbc;
	pwmc_pkg::rsp_t  res;
	logic            res_v;

	assign sbc   = sbc_d[pwmc_pkg::DIV_W-1];
	assign res_v = vc & vd;

	always_comb begin
		res = '0;
		res.clock_select = sbc.k;
		res.tag_echo     = sbc.tag;
		if (sbc.func == pwmc_pkg::MODE_PWM) begin
			res.actual_freq  = qc[26:0];
			res.actual_duty  = qd[13:0];
			res.period_count = sbc.period;
			res.pulse_count  = sbc.pulse;
			res.status       = (sbc.chan == pwmc_pkg::ONLY_CHANNEL) ? pwmc_pkg::ST_OK
				: pwmc_pkg::ST_CHAN;
			res.start_pair   = (sbc.chan == pwmc_pkg::ONLY_CHANNEL);
		end else if (sbc.func == pwmc_pkg::MODE_SQW) begin
			res.actual_freq  = qc[26:0];
			res.actual_duty  = pwmc_pkg::SQW_DUTY;
			res.period_count = sbc.period;
			res.status       = pwmc_pkg::ST_CHAN;
		end else if (sbc.func == pwmc_pkg::MODE_STOP) begin
			res.status       = (sbc.chan == pwmc_pkg::ONLY_CHANNEL) ? pwmc_pkg::ST_OK
				: pwmc_pkg::ST_CHAN;
			res.stop_channel = (sbc.chan == pwmc_pkg::ONLY_CHANNEL);
		end else begin
			res.status       = pwmc_pkg::ST_MODE;
		end
		res.reply_length = (res.status == pwmc_pkg::ST_OK) ? pwmc_pkg::LEN_OK
			: pwmc_pkg::LEN_ERR;
	end

	// ---------------- output register with skid slot ----------------
	logic           out_v_q;
	logic           skid_v_q;
	pwmc_pkg::rsp_t out_q;
	pwmc_pkg::rsp_t skid_q;
	logic           out_free;

	assign adv      = !skid_v_q;
	assign out_free = rsp.ready || !out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q  <= res_v;
			end
		end else if (adv && res_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (adv && res_v) begin
			skid_q <= res;
		end
	end

	assign cmd.ready        = adv;
	assign rsp.valid        = out_v_q;
	assign rsp.status       = out_q.status;
	assign rsp.reply_length = out_q.reply_length;
	assign rsp.actual_freq  = out_q.actual_freq;
	assign rsp.actual_duty  = out_q.actual_duty;
	assign rsp.period_count = out_q.period_count;
	assign rsp.pulse_count  = out_q.pulse_count;
	assign rsp.clock_select = out_q.clock_select;
	assign rsp.tag_echo     = out_q.tag_echo;
	assign rsp.start_pair   = out_q.start_pair;
	assign rsp.stop_channel = out_q.stop_channel;

endmodule
`default_nettype wire

// File: rtl/pwmc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwmc_div
// Pipelined restoring divider, 32 by 32 bits, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pwmc_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_valid,
	input  wire logic [31:0] num,
	input  wire logic [31:0] den,
	output logic             out_valid,
	output logic [31:0]      quo
);

	logic [pwmc_pkg::DIV_W-1:0] v_s;
	logic [31:0] rem_s [pwmc_pkg::DIV_W];
	logic [31:0] nq_s  [pwmc_pkg::DIV_W];
	logic [31:0] den_s [pwmc_pkg::DIV_W];

	logic [31:0] rem_n [pwmc_pkg::DIV_W];
	logic [31:0] nq_n  [pwmc_pkg::DIV_W];
	logic [31:0] den_n [pwmc_pkg::DIV_W];

	always_comb begin
		logic [31:0] pr;
		logic [31:0] pn;
		logic [32:0] trial;
		logic        ge;
		for (int j = 0; j < pwmc_pkg::DIV_W; j++) begin
			if (j == 0) begin
				pr = '0;
				pn = num;
				den_n[j] = den;
			end else begin
				pr = rem_s[j-1];
				pn = nq_s[j-1];
				den_n[j] = den_s[j-1];
			end
			trial = {pr, pn[31]};
			ge = (trial >= {1'b0, den_n[j]});
			rem_n[j] = ge ? 32'(trial - {1'b0, den_n[j]}) : trial[31:0];
			// dividend bits shift out the top, quotient bits shift in below
			nq_n[j] = {pn[30:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[pwmc_pkg::DIV_W-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < pwmc_pkg::DIV_W; j++) begin
				rem_s[j] <= rem_n[j];
				nq_s[j]  <= nq_n[j];
				den_s[j] <= den_n[j];
			end
		end
	end

	assign out_valid = v_s[pwmc_pkg::DIV_W-1];
	assign quo       = nq_s[pwmc_pkg::DIV_W-1];

endmodule
`default_nettype wire
